/* hdl/gbns_pkg.sv */
`default_nettype none
package gbns_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int WINDOW_SLOTS = 4;
  localparam int LIMIT_W      = 3;
  localparam int CNT_W        = 4;

  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [2:0] KIND_REFUSED  = 3'd0;
  localparam logic [2:0] KIND_TRANSMIT = 3'd1;
  localparam logic [2:0] KIND_TSTART   = 3'd2;
  localparam logic [2:0] KIND_TSTOP    = 3'd3;
  localparam logic [2:0] KIND_CORRUPT  = 3'd4;
  localparam logic [2:0] KIND_DUP      = 3'd5;
  localparam logic [2:0] KIND_OUTWIN   = 3'd6;
  localparam logic [2:0] KIND_IDLE     = 3'd7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
    logic                    checksum_ok;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              res_kind;
    logic [SEQ_W-1:0]        seq_num;
    logic [PAYLOAD_BITS-1:0] data_out;
    logic                    last;
  } out_word_t;

endpackage
`default_nettype wire

/* hdl/gbns_store.sv */
`default_nettype none
module gbns_store
  import gbns_pkg::*;
#(
  parameter int SLOTS  = WINDOW_SLOTS,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [SLOT_W-1:0]       wr_addr,
  input  wire logic [PAYLOAD_BITS-1:0] wr_data,
  input  wire logic [SLOT_W-1:0]       rd_addr,
  output logic      [PAYLOAD_BITS-1:0] rd_data
);

  logic [PAYLOAD_BITS-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/go_back_n_sender_window.sv */
// The first result follows the accepted start in the next cycle, then one per cycle.
// A send gives one or two results, an ack one to four (a timer stop per freed slot plus
// a restart, never more than the window slots), a timeout one, or two plus outstanding,
// from the one-entry-per-cycle walk of the payload ring memory; busy stays high until
// the last result is out. The receiver cannot stall: each result is valid for one cycle.
// Reset (rst, synchronous) empties the window, zeroes base and next sequence, limit 4.
`default_nettype none
module go_back_n_sender_window
  import gbns_pkg::*;
#(
  parameter int SLOTS = WINDOW_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    cmd,
  output logic             result_valid,
  output out_word_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [LIMIT_W-1:0] SLOT_LIMIT =
    (SLOTS < SEQ_SPACE - 1) ? LIMIT_W'(SLOTS) : LIMIT_W'(SEQ_SPACE - 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TX     = 3'd1;
  localparam logic [2:0] S_STOP   = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_TSTART = 3'd4;
  localparam logic [2:0] S_RETX   = 3'd5;

  logic [2:0]              state;
  logic [LIMIT_W-1:0]      window_limit;
  logic [SEQ_W-1:0]        window_base;
  logic [SEQ_W-1:0]        next_seq;
  logic [SEQ_W-1:0]        outstanding;
  logic [SLOT_W-1:0]       head;
  logic [SLOT_W-1:0]       rd_ptr;
  logic [SEQ_W-1:0]        cnt;
  logic [SEQ_W-1:0]        tx_seq;
  logic [PAYLOAD_BITS-1:0] pay_hold;

  logic [LIMIT_W-1:0]      lim;
  logic [CNT_W-1:0]        freed;
  logic [CNT_W-1:0]        wr_sum;
  logic [CNT_W-1:0]        head_sum;
  logic [SLOT_W-1:0]       wr_addr;
  logic [SLOT_W-1:0]       head_next;
  logic [SLOT_W-1:0]       rd_ptr_next;
  logic [SEQ_W-1:0]        remain;
  logic                    accept;
  logic                    wr_en;
  logic                    dup;
  logic [PAYLOAD_BITS-1:0] rd_data;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - LIMIT_W){1'b0}}, window_limit} : 32'd0;

  always_comb begin
    lim = (window_limit > SLOT_LIMIT) ? SLOT_LIMIT : window_limit;
  end

  assign freed  = {1'b0, cmd.ack_num - window_base} + CNT_W'(1);
  assign dup    = (cmd.ack_num == window_base - SEQ_W'(1));
  assign remain = outstanding - freed[SEQ_W-1:0];

  assign wr_sum   = CNT_W'(head) + CNT_W'(outstanding);
  assign wr_addr  = (wr_sum >= SLOTS_C) ? SLOT_W'(wr_sum - SLOTS_C) : SLOT_W'(wr_sum);
  assign head_sum = CNT_W'(head) + freed;
  assign head_next = (head_sum >= SLOTS_C) ? SLOT_W'(head_sum - SLOTS_C)
                                           : SLOT_W'(head_sum);
  assign rd_ptr_next = (rd_ptr == SLOT_W'(SLOTS - 1)) ? '0 : rd_ptr + SLOT_W'(1);

  assign wr_en = accept && (cmd.req_type == REQ_SEND) &&
                 (outstanding < lim);

  gbns_store #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.payload),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      window_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_base  <= '0;
      next_seq     <= '0;
      outstanding  <= '0;
      head         <= '0;
      rd_ptr       <= '0;
      cnt          <= '0;
      tx_seq       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.req_type)
              REQ_SEND: begin
                result_valid <= 1'b1;
                if (outstanding >= lim) begin
                  result <= '{KIND_REFUSED, '0, '0, 1'b1};
                end else begin
                  next_seq    <= next_seq + SEQ_W'(1);
                  outstanding <= outstanding + SEQ_W'(1);
                  pay_hold    <= cmd.payload;
                  tx_seq      <= next_seq;
                  if (outstanding == '0) begin
                    result <= '{KIND_TSTART, next_seq, '0, 1'b0};
                    state  <= S_TX;
                  end else begin
                    result <= '{KIND_TRANSMIT, next_seq, cmd.payload, 1'b1};
                  end
                end
              end
              REQ_ACK: begin
                result_valid <= 1'b1;
                if (!cmd.checksum_ok) begin
                  result <= '{KIND_CORRUPT, cmd.ack_num, '0, 1'b1};
                end else if (dup) begin
                  result <= '{KIND_DUP, cmd.ack_num, '0, 1'b1};
                end else if (freed > CNT_W'(outstanding)) begin
                  result <= '{KIND_OUTWIN, cmd.ack_num, '0, 1'b1};
                end else begin
                  outstanding <= remain;
                  head        <= head_next;
                  window_base <= window_base + SEQ_W'(1);
                  cnt         <= freed[SEQ_W-1:0] - SEQ_W'(1);
                  if (freed == CNT_W'(1)) begin
                    result <= '{KIND_TSTOP, window_base, '0, (remain == '0)};
                    state  <= (remain == '0) ? S_IDLE : S_START;
                  end else begin
                    result <= '{KIND_TSTOP, window_base, '0, 1'b0};
                    state  <= S_STOP;
                  end
                end
              end
              REQ_TIMEOUT: begin
                result_valid <= 1'b1;
                if (outstanding == '0) begin
                  result <= '{KIND_IDLE, window_base, '0, 1'b1};
                end else begin
                  result <= '{KIND_TSTOP, window_base, '0, 1'b0};
                  rd_ptr <= head;
                  cnt    <= outstanding;
                  tx_seq <= window_base;
                  state  <= S_TSTART;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_TX: begin
          result_valid <= 1'b1;
          result       <= '{KIND_TRANSMIT, tx_seq, pay_hold, 1'b1};
          state        <= S_IDLE;
        end
        S_STOP: begin
          result_valid <= 1'b1;
          window_base  <= window_base + SEQ_W'(1);
          cnt          <= cnt - SEQ_W'(1);
          if (cnt == SEQ_W'(1)) begin
            result <= '{KIND_TSTOP, window_base, '0, (outstanding == '0)};
            state  <= (outstanding == '0) ? S_IDLE : S_START;
          end else begin
            result <= '{KIND_TSTOP, window_base, '0, 1'b0};
          end
        end
        S_START: begin
          result_valid <= 1'b1;
          result       <= '{KIND_TSTART, window_base, '0, 1'b1};
          state        <= S_IDLE;
        end
        S_TSTART: begin
          result_valid <= 1'b1;
          result       <= '{KIND_TSTART, window_base, '0, 1'b0};
          rd_ptr       <= rd_ptr_next;
          state        <= S_RETX;
        end
        S_RETX: begin
          result_valid <= 1'b1;
          result       <= '{KIND_TRANSMIT, tx_seq, rd_data, (cnt == SEQ_W'(1))};
          tx_seq       <= tx_seq + SEQ_W'(1);
          cnt          <= cnt - SEQ_W'(1);
          rd_ptr       <= rd_ptr_next;
          if (cnt == SEQ_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/tb_go_back_n_sender_window.sv */
module tb_go_back_n_sender_window;
  timeunit 1ns;
  timeprecision 1ps;
  import gbns_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [2:0] LIMIT_ADDR = 3'd0;
  localparam logic [17:0] LIMIT_PLAN = {3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd1};
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 58;
  localparam int DIR_ROWS = 20;
  localparam int MAX_GAP = 30;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_word_t cmd;
  logic result_valid;
  out_word_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  go_back_n_sender_window u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // window shadow
  logic [LIMIT_W-1:0] win_limit;
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] next_seq;
  int in_flight;
  logic [PAYLOAD_BITS-1:0] held [WINDOW_SLOTS];

  out_word_t awaited[$];
  out_word_t fresh[$];
  out_word_t head;
  dir_row_t dir_rows [DIR_ROWS];

  int errors = 0;
  int n_results = 0;
  int n_refused = 0;
  int n_send = 0;
  int n_ack = 0;
  int n_timeout = 0;
  int n_spare = 0;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  function automatic void put(input logic [2:0] kind, input logic [SEQ_W-1:0] seq,
                              input logic [PAYLOAD_BITS-1:0] data);
    out_word_t r;
    r.res_kind = kind;
    r.seq_num = seq;
    r.data_out = data;
    r.last = 1'b0;
    fresh = {fresh, r};
  endfunction

  function automatic void advance_window(input in_word_t w);
    int lim;
    int freed;
    int i;
    logic [SEQ_W-1:0] dup_num;
    logic [SEQ_W-1:0] span;
    fresh.delete();
    lim = (win_limit > WINDOW_SLOTS) ? WINDOW_SLOTS : int'(win_limit);
    dup_num = win_base - 1'b1;
    span = w.ack_num - win_base;
    case (w.req_type)
      REQ_SEND: begin
        if (in_flight >= lim) begin
          put(KIND_REFUSED, '0, '0);
        end else begin
          held[in_flight] = w.payload;
          if (in_flight == 0) put(KIND_TSTART, next_seq, '0);
          put(KIND_TRANSMIT, next_seq, w.payload);
          next_seq = next_seq + 1'b1;
          in_flight++;
        end
      end
      REQ_ACK: begin
        if (!w.checksum_ok) begin
          put(KIND_CORRUPT, w.ack_num, '0);
        end else if (w.ack_num == dup_num) begin
          put(KIND_DUP, w.ack_num, '0);
        end else begin
          freed = int'(span) + 1;
          if (freed > in_flight) begin
            put(KIND_OUTWIN, w.ack_num, '0);
          end else begin
            for (i = 0; i < freed; i++) begin
              put(KIND_TSTOP, win_base, '0);
              win_base = win_base + 1'b1;
            end
            for (i = 0; i + freed < in_flight; i++) held[i] = held[i + freed];
            in_flight -= freed;
            if (in_flight != 0) put(KIND_TSTART, win_base, '0);
          end
        end
      end
      REQ_TIMEOUT: begin
        if (in_flight == 0) begin
          put(KIND_IDLE, win_base, '0);
        end else begin
          put(KIND_TSTOP, win_base, '0);
          put(KIND_TSTART, win_base, '0);
          for (i = 0; i < in_flight; i++) put(KIND_TRANSMIT, win_base + SEQ_W'(i), held[i]);
        end
      end
      default: ;
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  function automatic in_word_t pick_cmd();
    in_word_t w;
    int r;
    w.payload = $urandom;
    w.ack_num = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
    w.checksum_ok = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 42) begin
      w.req_type = REQ_SEND;
    end else if (r < 80) begin
      w.req_type = REQ_ACK;
      w.checksum_ok = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 65 && in_flight != 0) begin
        w.ack_num = win_base + SEQ_W'($urandom_range(0, in_flight - 1));
      end else if (r < 77) begin
        w.checksum_ok = 1'b0;
      end else if (r < 88) begin
        w.ack_num = win_base - 1'b1;
      end
    end else if (r < 96) begin
      w.req_type = REQ_TIMEOUT;
    end else begin
      w.req_type = REQ_SPARE;
    end
    return w;
  endfunction

  task automatic issue(input in_word_t w, input int idle_pct, input logic typed,
                       input out_word_t want);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (w.req_type)
      REQ_SEND: n_send++;
      REQ_ACK: n_ack++;
      REQ_TIMEOUT: n_timeout++;
      default: n_spare++;
    endcase
    advance_window(w);
    if (typed) begin
      awaited = {awaited, want};
    end else begin
      awaited = {awaited, fresh};
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (awaited.size() != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    win_limit = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(val))
      note_error($sformatf("window limit readback: expected %0d, got %h", val, prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      n_results++;
      if (result.res_kind == KIND_REFUSED) n_refused++;
      if (awaited.size() == 0) begin
        note_error($sformatf("unexpected result: kind %0d seq %0d data %h last %0b",
                             result.res_kind, result.seq_num, result.data_out, result.last));
      end else begin
        head = awaited[0];
        awaited.delete(0);
        if (result !== head)
          note_error($sformatf({"result mismatch: expected kind %0d seq %0d data %h last %0b,",
                                " got kind %0d seq %0d data %h last %0b"},
                               head.res_kind, head.seq_num, head.data_out, head.last,
                               result.res_kind, result.seq_num, result.data_out,
                               result.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_go_back_n_sender_window: FAIL");
    $finish;
  end

  initial begin
    int p;
    int done;
    int idle_pct;
    in_word_t w;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    win_limit = LIMIT_RESET;
    win_base = '0;
    next_seq = '0;
    in_flight = 0;

    dir_rows[0]  = {REQ_TIMEOUT, 32'h0000_0000, 3'd0, 1'b1, 1'b1, KIND_IDLE, 3'd0, 32'h0, 1'b1};
    dir_rows[1]  = {REQ_ACK, 32'h0000_0000, 3'd3, 1'b1, 1'b1, KIND_OUTWIN, 3'd3, 32'h0, 1'b1};
    dir_rows[2]  = {REQ_ACK, 32'h0000_0000, 3'd5, 1'b0, 1'b1, KIND_CORRUPT, 3'd5, 32'h0, 1'b1};
    dir_rows[3]  = {REQ_ACK, 32'h0000_0000, 3'd7, 1'b1, 1'b1, KIND_DUP, 3'd7, 32'h0, 1'b1};
    dir_rows[4]  = {REQ_SPARE, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[5]  = {REQ_SEND, 32'h0000_0000, 3'd0, 1'b0, 1'b0, out_word_t'(0)};
    dir_rows[6]  = {REQ_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[7]  = {REQ_SEND, 32'hA5A5_A5A5, 3'd2, 1'b0, 1'b0, out_word_t'(0)};
    dir_rows[8]  = {REQ_SEND, 32'h5A5A_5A5A, 3'd5, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[9]  = {REQ_SEND, 32'h1234_5678, 3'd0, 1'b1, 1'b1, KIND_REFUSED, 3'd0, 32'h0, 1'b1};
    dir_rows[10] = {REQ_TIMEOUT, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, out_word_t'(0)};
    dir_rows[11] = {REQ_ACK, 32'h0000_0000, 3'd1, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[12] = {REQ_ACK, 32'h0000_0000, 3'd1, 1'b1, 1'b1, KIND_DUP, 3'd1, 32'h0, 1'b1};
    dir_rows[13] = {REQ_ACK, 32'h0000_0000, 3'd6, 1'b1, 1'b1, KIND_OUTWIN, 3'd6, 32'h0, 1'b1};
    dir_rows[14] = {REQ_SEND, 32'h0F0F_0F0F, 3'd0, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[15] = {REQ_SEND, 32'hF0F0_F0F0, 3'd0, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[16] = {REQ_ACK, 32'h0000_0000, 3'd5, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[17] = {REQ_TIMEOUT, 32'h0000_0000, 3'd0, 1'b1, 1'b1, KIND_IDLE, 3'd6, 32'h0, 1'b1};
    dir_rows[18] = {REQ_SEND, 32'h8000_0001, 3'd0, 1'b1, 1'b0, out_word_t'(0)};
    dir_rows[19] = {REQ_ACK, 32'h0000_0000, 3'd6, 1'b1, 1'b0, out_word_t'(0)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      issue(dir_rows[i].w, 0, dir_rows[i].typed, dir_rows[i].want);

    for (p = 0; p < PHASES; p++) begin
      settle();
      set_limit(LIMIT_PLAN[3*p +: 3]);
      idle_pct = (p < 2) ? 28 : (p < 4) ? 84 : 0;
      done = 0;
      while (done < WORDS_PER_PHASE) begin
        w = pick_cmd();
        issue(w, idle_pct, 1'b0, out_word_t'(0));
        if (w.req_type != REQ_SPARE) done++;
      end
    end
    settle();
    repeat (20) @(posedge clk);

    if (awaited.size() != 0)
      note_error($sformatf("%0d expected results never arrived", awaited.size()));
    $display("Covered %0d sends, %0d acks, %0d timeouts and %0d ignored words over %0d limits.",
             n_send, n_ack, n_timeout, n_spare, PHASES + 1);
    $display("Checked %0d results (%0d refusals); %0d errors.", n_results, n_refused, errors);
    if (errors == 0) begin
      $display("tb_go_back_n_sender_window: PASS");
    end else begin
      $display("tb_go_back_n_sender_window: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/gbns_pkg.sv
hdl/gbns_store.sv
hdl/go_back_n_sender_window.sv
verif/tb_go_back_n_sender_window.sv
